[sv/sfr_pkg.sv]
package sfr_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   localparam int WEIGHT_W     = 4;
   localparam int IMG_WIDTH_W  = 11;
   localparam int IMG_HEIGHT_W = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;

   localparam int COLCMP_W = ((COL_W > IMG_WIDTH_W) ? COL_W : IMG_WIDTH_W) + 1;
   localparam int ROWCMP_W = ((ROW_W > IMG_HEIGHT_W) ? ROW_W : IMG_HEIGHT_W) + 1;

   localparam int WEIGHT_RESET     = 9;
   localparam int IMG_WIDTH_RESET  = 640;
   localparam int IMG_HEIGHT_RESET = 480;
   localparam int MIN_DIM          = 3;
   localparam int FIRST_INTERIOR   = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_WEIGHT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd2;

   localparam int CHAN_W     = 8;
   localparam int PIXEL_W    = 3 * CHAN_W;
   localparam int TAPS       = 9;
   localparam int CENTER_TAP = 4;
   localparam int PRODUCT_W  = WEIGHT_W + CHAN_W;
   localparam int SUM_W      = CHAN_W + 3;
   localparam int DIFF_W     = PRODUCT_W + 1;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
   localparam int OCC_W      = FIFO_CNT_W + 1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef logic [TAPS-1:0][CHAN_W-1:0] tap_array_type;

   typedef struct packed {
      pixel_type pixel;
      logic      frame_end;
   } result_type;

endpackage

[sv/sfr_ram.sv]
module sfr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sfr_lane.sv]
module sfr_lane
   import sfr_pkg::*;
(
   input  logic                clock,
   input  logic                load,
   input  tap_array_type       taps,
   input  logic [WEIGHT_W-1:0] center_weight,
   output logic [CHAN_W-1:0]   value
);

   logic        [PRODUCT_W-1:0] product_in;
   logic        [PRODUCT_W-1:0] product_ff;
   logic        [SUM_W-1:0]     sum_in;
   logic        [SUM_W-1:0]     sum_ff;
   logic signed [DIFF_W-1:0]    diff;

   always_comb begin
      product_in = PRODUCT_W'(center_weight) * PRODUCT_W'(taps[CENTER_TAP]);
      sum_in = '0;
      for (int i = 0; i < TAPS; i++) begin
         if (i != CENTER_TAP) begin
            sum_in = sum_in + SUM_W'(taps[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
         sum_ff     <= sum_in;
      end
   end

   always_comb begin
      diff = signed'({1'b0, product_ff}) - signed'(DIFF_W'(sum_ff));
      if (diff[DIFF_W-1]) begin
         value = '0;
      end else if (diff[DIFF_W-2:CHAN_W] != '0) begin
         value = '1;
      end else begin
         value = diff[CHAN_W-1:0];
      end
   end

endmodule

[sv/sfr_fifo.sv]
module sfr_fifo
   import sfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  result_type            push_data,
   input  logic                  pop,
   output logic                  out_valid,
   output result_type            out_data,
   output logic [FIFO_CNT_W-1:0] count
);

   result_type              entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic [FIFO_CNT_W-1:0]   count_in;
   logic                    do_pop;

   assign out_valid = count_ff != '0;
   assign out_data  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign do_pop    = pop & out_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/sharpen_filter_3x3_rgb.sv]
// Sharpens an RGB pixel stream with a 3x3 Laplacian kernel: for every interior pixel of a
// frame of image_width by image_height pixels it sends center_weight times the center minus
// the eight neighbors, per channel, clamped to 0..255, and border pixels give no result. The
// block takes one pixel per clock cycle for as long as results are taken. After a pixel's
// transfer, which also reads the line stores, the window shifts, the per-channel multiply
// and neighbor sum are registered, and the clamped value goes into an eight-entry output
// queue that offers the result; the input stalls only when that queue and the pipeline
// ahead of it together hold eight results. The last interior result of a frame carries tlast.
// The line stores hold no defined data after reset, so a frame starts the line stores afresh
// from its first two lines, and geometry should be written only while no frame is in progress.
module sharpen_filter_3x3_rgb
   import sfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // red_in, green_in, blue_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [PIXEL_W-1:0]     rsp_tdata,   // red_out, green_out, blue_out
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [WEIGHT_W-1:0]     center_weight_ff;
   logic [IMG_WIDTH_W-1:0]  image_width_ff;
   logic [IMG_HEIGHT_W-1:0] image_height_ff;

   logic [COL_W-1:0]        col_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [COLCMP_W-1:0]     width_ext;
   logic [COLCMP_W-1:0]     eff_width;
   logic [COLCMP_W-1:0]     col_ext;
   logic [ROWCMP_W-1:0]     height_ext;
   logic [ROWCMP_W-1:0]     eff_height;
   logic [ROWCMP_W-1:0]     row_ext;
   logic                    last_col;
   logic                    last_row;
   logic                    emit_now;

   logic                    req_accept;
   pixel_type               req_pixel;

   logic                    s1_valid_ff;
   logic                    s1_emit_ff;
   logic                    s1_last_ff;
   pixel_type               s1_pixel_ff;
   logic [COL_W-1:0]        s1_addr_ff;
   logic [PIXEL_W-1:0]      above_rd;
   logic [PIXEL_W-1:0]      above2_rd;

   pixel_type               window_ff [TAPS];
   pixel_type               window_in [TAPS];

   logic                    s2_valid_ff;
   logic                    s2_last_ff;
   logic                    s3_valid_ff;
   logic                    s3_last_ff;

   tap_array_type           taps_red;
   tap_array_type           taps_green;
   tap_array_type           taps_blue;
   result_type              lane_result;

   logic                    fifo_valid;
   result_type              fifo_data;
   logic [FIFO_CNT_W-1:0]   fifo_count;
   logic [OCC_W-1:0]        occupancy;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_weight_ff <= WEIGHT_W'(WEIGHT_RESET);
         image_width_ff   <= IMG_WIDTH_W'(IMG_WIDTH_RESET);
         image_height_ff  <= IMG_HEIGHT_W'(IMG_HEIGHT_RESET);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CENTER_WEIGHT: begin
               center_weight_ff <= csr_data[WEIGHT_W-1:0];
            end
            CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_data[IMG_WIDTH_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_data[IMG_HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      width_ext  = COLCMP_W'(image_width_ff);
      height_ext = ROWCMP_W'(image_height_ff);
      if (width_ext < COLCMP_W'(MIN_DIM)) begin
         eff_width = COLCMP_W'(MIN_DIM);
      end else if (width_ext > COLCMP_W'(MAX_WIDTH)) begin
         eff_width = COLCMP_W'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      if (height_ext < ROWCMP_W'(MIN_DIM)) begin
         eff_height = ROWCMP_W'(MIN_DIM);
      end else if (height_ext > ROWCMP_W'(MAX_HEIGHT)) begin
         eff_height = ROWCMP_W'(MAX_HEIGHT);
      end else begin
         eff_height = height_ext;
      end
      col_ext  = COLCMP_W'(col_ff);
      row_ext  = ROWCMP_W'(row_ff);
      last_col = col_ext >= eff_width - COLCMP_W'(1);
      last_row = row_ext >= eff_height - ROWCMP_W'(1);
      emit_now = (col_ff >= COL_W'(FIRST_INTERIOR)) && (row_ff >= ROW_W'(FIRST_INTERIOR));
   end

   assign occupancy = OCC_W'(fifo_count) + OCC_W'(s1_valid_ff & s1_emit_ff)
                    + OCC_W'(s2_valid_ff) + OCC_W'(s3_valid_ff);
   assign req_tready = occupancy < OCC_W'(FIFO_DEPTH);
   assign req_accept = req_tvalid & req_tready;

   assign req_pixel.red   = req_tdata[CHAN_W-1:0];
   assign req_pixel.green = req_tdata[2*CHAN_W-1:CHAN_W];
   assign req_pixel.blue  = req_tdata[3*CHAN_W-1:2*CHAN_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
         s1_last_ff  <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_last_ff  <= 1'b0;
         s3_valid_ff <= 1'b0;
         s3_last_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         s1_emit_ff  <= emit_now;
         s1_last_ff  <= last_col & last_row;
         s2_valid_ff <= s1_valid_ff & s1_emit_ff;
         s2_last_ff  <= s1_last_ff;
         s3_valid_ff <= s2_valid_ff;
         s3_last_ff  <= s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_pixel;
         s1_addr_ff  <= col_ff;
      end
   end

   sfr_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_above (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (above_rd)
   );

   sfr_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_above2 (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (above_rd),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (above2_rd)
   );

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         window_in[r*3]   = window_ff[r*3+1];
         window_in[r*3+1] = window_ff[r*3+2];
      end
      window_in[2] = above2_rd;
      window_in[5] = above_rd;
      window_in[8] = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            window_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         for (int i = 0; i < TAPS; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         taps_red[i]   = window_ff[i].red;
         taps_green[i] = window_ff[i].green;
         taps_blue[i]  = window_ff[i].blue;
      end
   end

   sfr_lane u_lane_red (
      .clock         (clock),
      .load          (s2_valid_ff),
      .taps          (taps_red),
      .center_weight (center_weight_ff),
      .value         (lane_result.pixel.red)
   );

   sfr_lane u_lane_green (
      .clock         (clock),
      .load          (s2_valid_ff),
      .taps          (taps_green),
      .center_weight (center_weight_ff),
      .value         (lane_result.pixel.green)
   );

   sfr_lane u_lane_blue (
      .clock         (clock),
      .load          (s2_valid_ff),
      .taps          (taps_blue),
      .center_weight (center_weight_ff),
      .value         (lane_result.pixel.blue)
   );

   assign lane_result.frame_end = s3_last_ff;

   sfr_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_data (lane_result),
      .pop       (rsp_tready),
      .out_valid (fifo_valid),
      .out_data  (fifo_data),
      .count     (fifo_count)
   );

   assign rsp_tvalid = fifo_valid;
   assign rsp_tdata  = {fifo_data.pixel.blue, fifo_data.pixel.green, fifo_data.pixel.red};
   assign rsp_tlast  = fifo_data.frame_end;

   // A result must never arrive at a full output queue.
   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)))
      else $error("result pushed into a full output queue");

   assert property (@(posedge clock) disable iff (reset)
      occupancy <= OCC_W'(FIFO_DEPTH))
      else $error("results in flight exceed the output queue depth");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && emit_now) |-> ##3 s3_valid_ff)
      else $error("interior pixel did not reach the clamp stage");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && last_col) |=> (col_ff == '0))
      else $error("column counter did not wrap at the end of a line");

endmodule

[tb/sharpen_stream_checker.sv]
`timescale 1ns / 100ps

module sharpen_stream_checker
   import sfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [PIXEL_W-1:0]     rsp_tdata,
   input  logic                   rsp_tlast,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     outstanding,
   output int                     failures
);

   localparam int CHAN_MAX = (1 << CHAN_W) - 1;

   pixel_type  line_near [MAX_WIDTH];
   pixel_type  line_far  [MAX_WIDTH];
   pixel_type  window    [3][3];
   result_type sharpened_q [$];

   logic [WEIGHT_W-1:0]     weight;
   logic [IMG_WIDTH_W-1:0]  width_reg;
   logic [IMG_HEIGHT_W-1:0] height_reg;
   int                      col_pos;
   int                      row_pos;

   function automatic pixel_type unpack_pixel(logic [PIXEL_W-1:0] bus);
      pixel_type p;
      p.red   = bus[CHAN_W-1:0];
      p.green = bus[2*CHAN_W-1:CHAN_W];
      p.blue  = bus[PIXEL_W-1:2*CHAN_W];
      return p;
   endfunction

   function automatic logic [CHAN_W-1:0] sharpen(int shift);
      int acc;
      int r;
      int c;
      acc = int'(weight) * int'(window[1][1][shift +: CHAN_W]);
      for (r = 0; r < 3; r++) begin
         for (c = 0; c < 3; c++) begin
            if (r != 1 || c != 1) begin
               acc -= int'(window[r][c][shift +: CHAN_W]);
            end
         end
      end
      if (acc < 0) begin
         acc = 0;
      end else if (acc > CHAN_MAX) begin
         acc = CHAN_MAX;
      end
      return acc[CHAN_W-1:0];
   endfunction

   task automatic take_pixel(pixel_type px);
      int         w;
      int         h;
      int         idx;
      int         r;
      bit         last_col;
      bit         last_row;
      pixel_type  above;
      pixel_type  above2;
      result_type res;
      w = (width_reg < MIN_DIM) ? MIN_DIM : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg < MIN_DIM) ? MIN_DIM : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      idx = col_pos % MAX_WIDTH;
      above2 = line_far[idx];
      above = line_near[idx];
      last_col = col_pos >= w - 1;
      last_row = row_pos >= h - 1;
      line_far[idx] = above;
      line_near[idx] = px;
      for (r = 0; r < 3; r++) begin
         window[r][0] = window[r][1];
         window[r][1] = window[r][2];
      end
      window[0][2] = above2;
      window[1][2] = above;
      window[2][2] = px;
      if (col_pos >= FIRST_INTERIOR && row_pos >= FIRST_INTERIOR) begin
         res.pixel.red = sharpen(2 * CHAN_W);
         res.pixel.green = sharpen(CHAN_W);
         res.pixel.blue = sharpen(0);
         res.frame_end = last_col && last_row;
         sharpened_q = {sharpened_q, res};
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   task automatic compare_field(string field, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      pixel_type  got;
      result_type want;
      int         r;
      int         c;
      if (reset) begin
         weight = WEIGHT_W'(WEIGHT_RESET);
         width_reg = IMG_WIDTH_W'(IMG_WIDTH_RESET);
         height_reg = IMG_HEIGHT_W'(IMG_HEIGHT_RESET);
         for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
               window[r][c] = '0;
            end
         end
         col_pos = 0;
         row_pos = 0;
         sharpened_q.delete();
         failures = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTER_WEIGHT: weight = csr_data[WEIGHT_W-1:0];
               CSR_IMAGE_WIDTH:   width_reg = csr_data[IMG_WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT:  height_reg = csr_data[IMG_HEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_pixel(rsp_tdata);
            if (sharpened_q.size() == 0) begin
               $error("unexpected result transfer: red_out %0d green_out %0d blue_out %0d",
                      got.red, got.green, got.blue);
               failures++;
            end else begin
               want = sharpened_q.pop_front();
               compare_field("red_out", want.pixel.red, got.red);
               compare_field("green_out", want.pixel.green, got.green);
               compare_field("blue_out", want.pixel.blue, got.blue);
               compare_field("frame_end", CHAN_W'(want.frame_end), CHAN_W'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            take_pixel(unpack_pixel(req_tdata));
         end
      end
      outstanding = sharpened_q.size();
   end

endmodule

[tb/tb_sharpen_filter_3x3_rgb.sv]
`timescale 1ns / 100ps

module tb_sharpen_filter_3x3_rgb;
   import sfr_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [CSR_DATA_W-1:0]  CSR_ALL_ONES = '1;

   localparam int STYLE_NOISE   = 0;
   localparam int STYLE_EXTREME = 1;
   localparam int STYLE_FLAT    = 2;

   localparam int RANDOM_ITEMS  = 700;
   localparam int CALM_ITEMS    = 120;
   localparam int SETTLE_CYCLES = 10;
   localparam int PARTIAL_ITEMS = 40;
   localparam int CYCLE_LIMIT   = 2000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [PIXEL_W-1:0]     rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int outstanding;
   int failures;
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int pixel_count = 0;

   sharpen_filter_3x3_rgb dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sharpen_stream_checker sharpen_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .failures    (failures)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(1, 19);
         rsp_tready <= 1'b0;
      end
   end

   function automatic logic [PIXEL_W-1:0] rgb(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                              logic [CHAN_W-1:0] b);
      return {b, g, r};
   endfunction

   function automatic int span(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic logic [PIXEL_W-1:0] make_pixel(int style, int base);
      logic [PIXEL_W-1:0] px;
      int                 ch;
      px = PIXEL_W'($urandom);
      for (ch = 0; ch < 3; ch++) begin
         if (style == STYLE_EXTREME) begin
            px[ch*CHAN_W +: CHAN_W] = {CHAN_W{1'($urandom_range(0, 1))}};
         end else if (style == STYLE_FLAT) begin
            px[ch*CHAN_W +: CHAN_W] = CHAN_W'(span(base + $urandom_range(0, 16) - 8, 0, 255));
         end
      end
      return px;
   endfunction

   task automatic send_pixel(logic [PIXEL_W-1:0] px);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
      pixel_count++;
   endtask

   task automatic send_run(int count, int style);
      int base;
      int i;
      base = $urandom_range(0, 255);
      for (i = 0; i < count; i++) begin
         send_pixel(make_pixel(style, base));
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(int weight_val, int width_val, int height_val,
                                bit poke_unused);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [CSR_DATA_W-1:0]  val [4];
      int                     i;
      idx[0] = CSR_CENTER_WEIGHT;
      val[0] = CSR_DATA_W'(weight_val);
      idx[1] = CSR_IMAGE_WIDTH;
      val[1] = CSR_DATA_W'(width_val);
      idx[2] = CSR_IMAGE_HEIGHT;
      val[2] = CSR_DATA_W'(height_val);
      idx[3] = CSR_UNUSED;
      val[3] = CSR_ALL_ONES;
      for (i = 0; i < (poke_unused ? 4 : 3); i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      int i;
      int start;
      int width_val;
      int height_val;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A lone bright center with the largest weight saturates the red channel high.
      set_registers(15, 1, 2, 1'b0);
      for (i = 0; i < 9; i++) begin
         send_pixel((i == 4) ? rgb(255, 17, 0) : rgb(0, 0, 0));
      end
      drain();

      // Weight zero under full-scale neighbors saturates low.
      set_registers(0, 3, 3, 1'b1);
      repeat (9) send_pixel(rgb(255, 255, 255));
      drain();

      set_registers(9, 3, 3, 1'b0);
      send_run(9, STYLE_FLAT);
      drain();

      // Shrink the geometry in the middle of a frame so both counters wrap early.
      set_registers($urandom_range(0, 15), 8, 6, 1'b0);
      send_run(29, STYLE_NOISE);
      drain();
      set_registers($urandom_range(0, 15), 4, 4, 1'b0);
      send_run(1, STYLE_NOISE);
      drain();

      // Oversized geometry is held at the largest width and height over short partial frames.
      gap_pct <= 5;
      stall_pct <= 5;
      set_registers($urandom_range(0, 15), CSR_ALL_ONES, 3, 1'b0);
      send_run(PARTIAL_ITEMS, STYLE_NOISE);
      drain();
      set_registers($urandom_range(0, 15), 3, CSR_ALL_ONES, 1'b0);
      send_run(PARTIAL_ITEMS, STYLE_NOISE);
      drain();

      start = pixel_count;
      while (pixel_count - start < RANDOM_ITEMS) begin
         if (pixel_count - start >= RANDOM_ITEMS - CALM_ITEMS) begin
            gap_pct <= 0;
            stall_pct <= 0;
         end else begin
            gap_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
            stall_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
         end
         width_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
         height_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
         set_registers($urandom_range(0, 8191), width_val, height_val, 1'b0);
         repeat ($urandom_range(1, 2)) begin
            send_run(span(width_val, MIN_DIM, MAX_WIDTH) * span(height_val, MIN_DIM, MAX_HEIGHT),
                     $urandom_range(STYLE_NOISE, STYLE_FLAT));
         end
         drain();
      end

      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
